FILE: hw/rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// shared types, codes and helpers of the http response head parser
// ----------------------------------------------------------------------------
package hrhp_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] KIND_SYNTAX = 3'd0;
    localparam logic [2:0] KIND_TEXT   = 3'd1;
    localparam logic [2:0] KIND_NAME   = 3'd2;
    localparam logic [2:0] KIND_VALUE  = 3'd3;
    localparam logic [2:0] KIND_BODY   = 3'd4;

    localparam logic [1:0] STAT_CONT      = 2'd0;
    localparam logic [1:0] STAT_LINE_DONE = 2'd1;
    localparam logic [1:0] STAT_HEAD_DONE = 2'd2;
    localparam logic [1:0] STAT_ERROR     = 2'd3;

    localparam logic [15:0] ACC_MAX = 16'hFFFF;

    // byte classes found by the front end
    typedef struct packed {
        logic is_digit;
        logic is_alpha;
        logic is_token;
        logic is_ctl;
        logic is_sp;
        logic is_ht;
        logic is_cr;
        logic is_lf;
        logic is_colon;
        logic is_dot;
        logic is_slash;
        logic is_h;
        logic is_t;
        logic is_p;
    } byte_class_t;

    // one queued item: raw byte plus its classes
    typedef struct packed {
        logic [7:0]  data;
        byte_class_t cls;
    } entry_t;

    function automatic logic is_separator(input logic [7:0] c);
        logic sep;
        sep = (c == 8'h28) || (c == 8'h29) || (c == 8'h3C) || (c == 8'h3E) ||
              (c == 8'h40) || (c == 8'h2C) || (c == 8'h3B) || (c == 8'h3A) ||
              (c == 8'h5C) || (c == 8'h22) || (c == 8'h2F) || (c == 8'h5B) ||
              (c == 8'h5D) || (c == 8'h3F) || (c == 8'h3D) || (c == 8'h7B) ||
              (c == 8'h7D);
        return sep;
    endfunction

    // acc * 10 + digit, saturating at 16 bits
    function automatic logic [15:0] acc_digit(input logic [15:0] acc,
                                              input logic [3:0]  dig);
        logic [19:0] sum;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'h0000, dig};
        return (sum > 20'(ACC_MAX)) ? ACC_MAX : sum[15:0];
    endfunction

endpackage

FILE: hw/rtl/hrhp_classify.sv
// ----------------------------------------------------------------------------
// hrhp_classify
// front end: accepts bytes and tags each with its character classes
// ----------------------------------------------------------------------------
module hrhp_classify
(
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [7:0]        data_byte,
    input  logic              queue_full,
    output logic              push,
    output hrhp_pkg::entry_t  push_entry
);

    hrhp_pkg::byte_class_t cls;

    always_comb
    begin
        cls.is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
        cls.is_alpha = ((data_byte >= 8'h41) && (data_byte <= 8'h5A)) ||
                       ((data_byte >= 8'h61) && (data_byte <= 8'h7A));
        cls.is_token = (data_byte > 8'h20) && (data_byte < 8'h7F) &&
                       !hrhp_pkg::is_separator(data_byte);
        cls.is_ctl   = (data_byte < 8'h20) || (data_byte == 8'h7F);
        cls.is_sp    = (data_byte == 8'h20);
        cls.is_ht    = (data_byte == 8'h09);
        cls.is_cr    = (data_byte == 8'h0D);
        cls.is_lf    = (data_byte == 8'h0A);
        cls.is_colon = (data_byte == 8'h3A);
        cls.is_dot   = (data_byte == 8'h2E);
        cls.is_slash = (data_byte == 8'h2F);
        cls.is_h     = (data_byte == 8'h48);
        cls.is_t     = (data_byte == 8'h54);
        cls.is_p     = (data_byte == 8'h50);
    end

    assign byte_ready      = !queue_full;
    assign push            = byte_valid && !queue_full;
    assign push_entry.data = data_byte;
    assign push_entry.cls  = cls;

endmodule

FILE: hw/rtl/hrhp_queue.sv
// ----------------------------------------------------------------------------
// hrhp_queue
// short register queue between the classifier and the parse engine
// ----------------------------------------------------------------------------
module hrhp_queue
#(
    parameter int DEPTH = hrhp_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hrhp_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output hrhp_pkg::entry_t  head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hrhp_pkg::entry_t slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hw/rtl/hrhp_engine.sv
// ----------------------------------------------------------------------------
// hrhp_engine
// back end: parse state machine, number accumulators and result register
// ----------------------------------------------------------------------------
module hrhp_engine
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  hrhp_pkg::entry_t  head,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [7:0]        byte_out,
    output logic [2:0]        byte_kind,
    output logic              header_begin,
    output logic [1:0]        parse_status,
    output logic [15:0]       major_version,
    output logic [15:0]       minor_version,
    output logic [15:0]       status_code
);

    localparam logic [4:0] PH_H         = 5'd0;
    localparam logic [4:0] PH_T1        = 5'd1;
    localparam logic [4:0] PH_T2        = 5'd2;
    localparam logic [4:0] PH_P         = 5'd3;
    localparam logic [4:0] PH_SLASH     = 5'd4;
    localparam logic [4:0] PH_MAJ0      = 5'd5;
    localparam logic [4:0] PH_MAJ       = 5'd6;
    localparam logic [4:0] PH_MIN0      = 5'd7;
    localparam logic [4:0] PH_MIN       = 5'd8;
    localparam logic [4:0] PH_CODE0     = 5'd9;
    localparam logic [4:0] PH_CODE      = 5'd10;
    localparam logic [4:0] PH_TEXT0     = 5'd11;
    localparam logic [4:0] PH_TEXT      = 5'd12;
    localparam logic [4:0] PH_LF_STATUS = 5'd13;
    localparam logic [4:0] PH_HDR       = 5'd14;
    localparam logic [4:0] PH_FOLD      = 5'd15;
    localparam logic [4:0] PH_NAME      = 5'd16;
    localparam logic [4:0] PH_SP        = 5'd17;
    localparam logic [4:0] PH_VALUE     = 5'd18;
    localparam logic [4:0] PH_LF_HDR    = 5'd19;
    localparam logic [4:0] PH_LF_HEAD   = 5'd20;
    localparam logic [4:0] PH_BODY      = 5'd21;
    localparam logic [4:0] PH_ERR       = 5'd22;

    logic [4:0]  phase_reg;
    logic [4:0]  phase_next;
    logic [15:0] major_reg;
    logic [15:0] major_next;
    logic [15:0] minor_reg;
    logic [15:0] minor_next;
    logic [15:0] code_reg;
    logic [15:0] code_next;
    logic        seen_reg;
    logic        seen_next;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic [2:0]  kind_reg;
    logic        begin_reg;
    logic [1:0]  status_reg;

    logic [2:0]  kind;
    logic        hbegin;
    logic [1:0]  status;
    logic        bad;
    logic [3:0]  dig;
    hrhp_pkg::byte_class_t c;

    assign c    = head.cls;
    assign dig  = head.data[3:0];
    assign pop  = head_valid && (!valid_reg || result_ready);

    always_comb
    begin
        phase_next = phase_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        code_next  = code_reg;
        seen_next  = seen_reg;
        kind       = hrhp_pkg::KIND_SYNTAX;
        hbegin     = 1'b0;
        status     = hrhp_pkg::STAT_CONT;
        bad        = 1'b0;
        unique case (phase_reg)
            PH_H:     if (c.is_h) phase_next = PH_T1; else bad = 1'b1;
            PH_T1:    if (c.is_t) phase_next = PH_T2; else bad = 1'b1;
            PH_T2:    if (c.is_t) phase_next = PH_P; else bad = 1'b1;
            PH_P:     if (c.is_p) phase_next = PH_SLASH; else bad = 1'b1;
            PH_SLASH:
            begin
                if (c.is_slash)
                begin
                    major_next = '0;
                    minor_next = '0;
                    phase_next = PH_MAJ0;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PH_MAJ0, PH_MAJ:
            begin
                if (phase_reg == PH_MAJ && c.is_dot)
                begin
                    phase_next = PH_MIN0;
                end
                else if (c.is_digit)
                begin
                    major_next = hrhp_pkg::acc_digit(major_reg, dig);
                    phase_next = PH_MAJ;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PH_MIN0, PH_MIN:
            begin
                if (phase_reg == PH_MIN && c.is_sp)
                begin
                    code_next  = '0;
                    phase_next = PH_CODE0;
                end
                else if (c.is_digit)
                begin
                    minor_next = hrhp_pkg::acc_digit(minor_reg, dig);
                    phase_next = PH_MIN;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PH_CODE0, PH_CODE:
            begin
                if (phase_reg == PH_CODE && c.is_sp)
                begin
                    phase_next = PH_TEXT0;
                end
                else if (c.is_digit)
                begin
                    code_next  = hrhp_pkg::acc_digit(code_reg, dig);
                    phase_next = PH_CODE;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PH_TEXT0, PH_TEXT:
            begin
                if (phase_reg == PH_TEXT && c.is_cr)
                begin
                    phase_next = PH_LF_STATUS;
                end
                else if (c.is_alpha)
                begin
                    kind       = hrhp_pkg::KIND_TEXT;
                    phase_next = PH_TEXT;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PH_LF_STATUS:
            begin
                if (c.is_lf)
                begin
                    status     = hrhp_pkg::STAT_LINE_DONE;
                    phase_next = PH_HDR;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PH_HDR:
            begin
                if (c.is_cr)
                begin
                    phase_next = PH_LF_HEAD;
                end
                else if (seen_reg && (c.is_sp || c.is_ht))
                begin
                    phase_next = PH_FOLD;
                end
                else if (c.is_token)
                begin
                    kind       = hrhp_pkg::KIND_NAME;
                    hbegin     = 1'b1;
                    seen_next  = 1'b1;
                    phase_next = PH_NAME;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PH_FOLD:
            begin
                if (c.is_cr)
                begin
                    phase_next = PH_LF_HDR;
                end
                else if (c.is_sp || c.is_ht)
                begin
                    phase_next = PH_FOLD;
                end
                else if (c.is_ctl)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    kind       = hrhp_pkg::KIND_VALUE;
                    phase_next = PH_VALUE;
                end
            end
            PH_NAME:
            begin
                if (c.is_colon)
                begin
                    phase_next = PH_SP;
                end
                else if (c.is_token)
                begin
                    kind = hrhp_pkg::KIND_NAME;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PH_SP:    if (c.is_sp) phase_next = PH_VALUE; else bad = 1'b1;
            PH_VALUE:
            begin
                if (c.is_cr)
                begin
                    phase_next = PH_LF_HDR;
                end
                else if (c.is_ctl)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    kind = hrhp_pkg::KIND_VALUE;
                end
            end
            PH_LF_HDR: if (c.is_lf) phase_next = PH_HDR; else bad = 1'b1;
            PH_LF_HEAD:
            begin
                if (c.is_lf)
                begin
                    status     = hrhp_pkg::STAT_HEAD_DONE;
                    phase_next = PH_BODY;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PH_BODY:  kind = hrhp_pkg::KIND_BODY;
            default:  bad = 1'b1;
        endcase
        // sticky error, accumulators keep their values
        if (bad)
        begin
            phase_next = PH_ERR;
            kind       = hrhp_pkg::KIND_SYNTAX;
            hbegin     = 1'b0;
            status     = hrhp_pkg::STAT_ERROR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_H;
            major_reg <= '0;
            minor_reg <= '0;
            code_reg  <= '0;
            seen_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                major_reg <= major_next;
                minor_reg <= minor_next;
                code_reg  <= code_next;
                seen_reg  <= seen_next;
                valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg   <= head.data;
            kind_reg   <= kind;
            begin_reg  <= hbegin;
            status_reg <= status;
        end
    end

    assign result_valid  = valid_reg;
    assign byte_out      = byte_reg;
    assign byte_kind     = kind_reg;
    assign header_begin  = begin_reg;
    assign parse_status  = status_reg;
    // accumulators only change on pop, so they match the registered item
    assign major_version = major_reg;
    assign minor_version = minor_reg;
    assign status_code   = code_reg;

endmodule

FILE: hw/rtl/http_response_head_parser_core.sv
// ----------------------------------------------------------------------------
// http_response_head_parser_core
// byte-serial parser for an http response status line and header block
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------
//  input    | byte_valid / byte_ready     | data_byte
//  result   | result_valid / result_ready | byte_out, byte_kind, header_begin,
//           |                             | parse_status, major_version,
//           |                             | minor_version, status_code
//
//  one item per clock sustained while result_ready stays high, one result per item
//  in order; each byte is written into the queue, then parsed into the result register
//  the queue (QUEUE_DEPTH items) lets the classifier keep taking bytes while
//  a finished result waits downstream; byte_ready drops only when it is full
//  rst_n clears queue pointers, parse phase, accumulators and result valid
//
module http_response_head_parser_core
#(
    parameter int QUEUE_DEPTH = hrhp_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  byte_out,
    output logic [2:0]  byte_kind,
    output logic        header_begin,
    output logic [1:0]  parse_status,
    output logic [15:0] major_version,
    output logic [15:0] minor_version,
    output logic [15:0] status_code
);

    // front to queue
    logic             push;
    hrhp_pkg::entry_t push_entry;
    logic             queue_full;

    // queue to back
    logic             head_valid;
    hrhp_pkg::entry_t head;
    logic             pop;

    // front end: character classes are found once, at accept time
    hrhp_classify u_classify
    (
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .data_byte  (data_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouples input acceptance from result backpressure
    hrhp_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (head_valid),
        .head       (head)
    );

    // back end: phase machine and accumulators, one item per cycle unless stalled
    hrhp_engine u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .byte_out      (byte_out),
        .byte_kind     (byte_kind),
        .header_begin  (header_begin),
        .parse_status  (parse_status),
        .major_version (major_version),
        .minor_version (minor_version),
        .status_code   (status_code)
    );

endmodule

FILE: tb/tb_http_response_head_parser_core.sv
// ----------------------------------------------------------------------------
// tb_http_response_head_parser_core
// self-checking bench for the byte-serial http response head parser
// ----------------------------------------------------------------------------
// A fixed status line pushes the major version, the minor version and the
// status code past 16 bits. It is followed by random header lines, until
// 380 bytes are sent in all: token names, values that include high bytes, and
// folded continuation lines. The stream then ends either with the empty
// line and body bytes, or with raw noise that drives the parser into its
// sticky error state. Every accepted byte goes through a local model of the
// parser. Every accepted result is checked field by field against the
// oldest prediction. Both sides stall at random, except in one window.
// ----------------------------------------------------------------------------
module tb_http_response_head_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // where the parser stands in the response head
    typedef enum logic [4:0] {
        SEEK_H, SEEK_T1, SEEK_T2, SEEK_P, SEEK_SLASH,
        MAJOR_FIRST, MAJOR_MORE, MINOR_FIRST, MINOR_MORE,
        CODE_FIRST, CODE_MORE, TEXT_FIRST, TEXT_MORE, STATUS_LF,
        LINE_START, FOLD_LEAD, NAME_MORE, AFTER_COLON, VALUE_MORE,
        HEADER_LF, HEAD_LF, BODY_PASS, HALTED
    } phase_t;

    // one tagged byte as the parser reports it
    typedef struct packed {
        logic [7:0]  data;
        logic [2:0]  kind;
        logic        hdr_begin;
        logic [1:0]  status;
        logic [15:0] major;
        logic [15:0] minor;
        logic [15:0] code;
    } tag_t;

    // tracks the parse of the byte stream and checks the tagged bytes
    class head_tag_checker;
        phase_t      phase;
        logic [15:0] major;
        logic [15:0] minor;
        logic [15:0] code;
        logic        header_seen;
        tag_t        expected_tags[$];
        int          fails;

        function new();
            phase       = SEEK_H;
            major       = '0;
            minor       = '0;
            code        = '0;
            header_seen = 1'b0;
            fails       = 0;
        endfunction

        static function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        static function bit is_alpha(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        static function bit is_ctl(logic [7:0] c);
            return c < 8'd32 || c == CH_DEL;
        endfunction

        static function bit is_token(logic [7:0] c);
            if (c <= 8'd32 || c >= 8'd127)
                return 1'b0;
            case (c)
                "(", ")", "<", ">", "@", ",", ";", ":", 8'h5C, 8'h22,
                "/", "[", "]", "?", "=", "{", "}":
                    return 1'b0;
                default:
                    return 1'b1;
            endcase
        endfunction

        // acc * 10 + digit, held at the 16-bit ceiling
        static function logic [15:0] push_digit(logic [15:0] acc, logic [7:0] c);
            int v;
            v = int'(acc) * 10 + int'(c) - 48;
            return (v > 65535) ? 16'hFFFF : 16'(v);
        endfunction

        function void note_byte(logic [7:0] c);
            tag_t   t;
            phase_t nxt;
            bit     bad;
            t.data      = c;
            t.kind      = hrhp_pkg::KIND_SYNTAX;
            t.hdr_begin = 1'b0;
            t.status    = hrhp_pkg::STAT_CONT;
            nxt         = phase;
            bad         = 1'b0;
            case (phase)
                SEEK_H:  if (c == "H") nxt = SEEK_T1; else bad = 1'b1;
                SEEK_T1: if (c == "T") nxt = SEEK_T2; else bad = 1'b1;
                SEEK_T2: if (c == "T") nxt = SEEK_P; else bad = 1'b1;
                SEEK_P:  if (c == "P") nxt = SEEK_SLASH; else bad = 1'b1;
                SEEK_SLASH:
                    if (c == "/")
                    begin
                        major = '0;
                        minor = '0;
                        nxt   = MAJOR_FIRST;
                    end
                    else
                        bad = 1'b1;
                MAJOR_FIRST, MAJOR_MORE:
                    if (phase == MAJOR_MORE && c == ".")
                        nxt = MINOR_FIRST;
                    else if (is_digit(c))
                    begin
                        major = push_digit(major, c);
                        nxt   = MAJOR_MORE;
                    end
                    else
                        bad = 1'b1;
                MINOR_FIRST, MINOR_MORE:
                    if (phase == MINOR_MORE && c == CH_SP)
                    begin
                        code = '0;
                        nxt  = CODE_FIRST;
                    end
                    else if (is_digit(c))
                    begin
                        minor = push_digit(minor, c);
                        nxt   = MINOR_MORE;
                    end
                    else
                        bad = 1'b1;
                CODE_FIRST, CODE_MORE:
                    if (phase == CODE_MORE && c == CH_SP)
                        nxt = TEXT_FIRST;
                    else if (is_digit(c))
                    begin
                        code = push_digit(code, c);
                        nxt  = CODE_MORE;
                    end
                    else
                        bad = 1'b1;
                TEXT_FIRST, TEXT_MORE:
                    if (phase == TEXT_MORE && c == CH_CR)
                        nxt = STATUS_LF;
                    else if (is_alpha(c))
                    begin
                        t.kind = hrhp_pkg::KIND_TEXT;
                        nxt    = TEXT_MORE;
                    end
                    else
                        bad = 1'b1;
                STATUS_LF:
                    if (c == CH_LF)
                    begin
                        t.status = hrhp_pkg::STAT_LINE_DONE;
                        nxt      = LINE_START;
                    end
                    else
                        bad = 1'b1;
                LINE_START:
                    if (c == CH_CR)
                        nxt = HEAD_LF;
                    else if (header_seen && (c == CH_SP || c == CH_HT))
                        nxt = FOLD_LEAD;
                    else if (is_token(c))
                    begin
                        t.kind      = hrhp_pkg::KIND_NAME;
                        t.hdr_begin = 1'b1;
                        header_seen = 1'b1;
                        nxt         = NAME_MORE;
                    end
                    else
                        bad = 1'b1;
                FOLD_LEAD:
                    if (c == CH_CR)
                        nxt = HEADER_LF;
                    else if (c == CH_SP || c == CH_HT)
                        nxt = FOLD_LEAD;
                    else if (is_ctl(c))
                        bad = 1'b1;
                    else
                    begin
                        t.kind = hrhp_pkg::KIND_VALUE;
                        nxt    = VALUE_MORE;
                    end
                NAME_MORE:
                    if (c == CH_COLON)
                        nxt = AFTER_COLON;
                    else if (is_token(c))
                        t.kind = hrhp_pkg::KIND_NAME;
                    else
                        bad = 1'b1;
                AFTER_COLON: if (c == CH_SP) nxt = VALUE_MORE; else bad = 1'b1;
                VALUE_MORE:
                    if (c == CH_CR)
                        nxt = HEADER_LF;
                    else if (is_ctl(c))
                        bad = 1'b1;
                    else
                        t.kind = hrhp_pkg::KIND_VALUE;
                HEADER_LF: if (c == CH_LF) nxt = LINE_START; else bad = 1'b1;
                HEAD_LF:
                    if (c == CH_LF)
                    begin
                        t.status = hrhp_pkg::STAT_HEAD_DONE;
                        nxt      = BODY_PASS;
                    end
                    else
                        bad = 1'b1;
                BODY_PASS: t.kind = hrhp_pkg::KIND_BODY;
                default:   bad = 1'b1;
            endcase
            if (bad)
            begin
                nxt         = HALTED;
                t.kind      = hrhp_pkg::KIND_SYNTAX;
                t.hdr_begin = 1'b0;
                t.status    = hrhp_pkg::STAT_ERROR;
            end
            phase   = nxt;
            t.major = major;
            t.minor = minor;
            t.code  = code;
            expected_tags = {expected_tags, t};
        endfunction

        function void match_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                fails++;
            end
        endfunction

        function void check_tag(tag_t got);
            tag_t want;
            if (expected_tags.size() == 0)
            begin
                $error("result item with no byte outstanding");
                fails++;
                return;
            end
            want = expected_tags.pop_front();
            match_field("byte_out", want.data, got.data);
            match_field("byte_kind", want.kind, got.kind);
            match_field("header_begin", want.hdr_begin, got.hdr_begin);
            match_field("parse_status", want.status, got.status);
            match_field("major_version", want.major, got.major);
            match_field("minor_version", want.minor, got.minor);
            match_field("status_code", want.code, got.code);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [7:0]  byte_out;
    logic [2:0]  byte_kind;
    logic        header_begin;
    logic [1:0]  parse_status;
    logic [15:0] major_version;
    logic [15:0] minor_version;
    logic [15:0] status_code;

    // calm window: neither side stalls
    logic        calm = 1'b0;
    int          sent = 0;
    int          cycles = 0;

    head_tag_checker tracker = new();

    http_response_head_parser_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .data_byte     (data_byte),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .byte_out      (byte_out),
        .byte_kind     (byte_kind),
        .header_begin  (header_begin),
        .parse_status  (parse_status),
        .major_version (major_version),
        .minor_version (minor_version),
        .status_code   (status_code)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // downstream drops result_ready at random, one time in five, outside the calm window
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (calm)
            result_ready <= 1'b1;
        else
            result_ready <= ($urandom_range(99) >= 20);
    end

    // both handshakes sampled at the edge; the byte is noted before the result
    // is checked so a result taken at the same edge as its byte would still line up
    always @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            tracker.note_byte(data_byte);
        if (result_valid && result_ready)
            tracker.check_tag(tag_t'{byte_out, byte_kind, header_begin, parse_status,
                                     major_version, minor_version, status_code});
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // offer one item, at times with a random idle gap in front of it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 20)
            gap = $urandom_range(3, 1);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        sent++;
    endtask

    // hold the input side until every predicted item has come back
    task automatic wait_drained();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_tags.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_token();
        logic [7:0] c;
        do
            c = 8'($urandom_range(126, 33));
        while (!head_tag_checker::is_token(c));
        return c;
    endfunction

    // any byte that a header value may carry, high bytes included
    function automatic logic [7:0] random_value_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255, 32));
        while (c == CH_DEL);
        return c;
    endfunction

    task automatic send_value(input int len);
        repeat (len) send_byte(random_value_byte());
    endtask

    // one header line, sometimes followed by a folded continuation
    task automatic send_header_line();
        repeat ($urandom_range(8, 1)) send_byte(random_token());
        send_byte(CH_COLON);
        send_byte(CH_SP);
        send_value($urandom_range(12, 0));
        send_byte(CH_CR);
        send_byte(CH_LF);
        if ($urandom_range(3) == 0)
        begin
            repeat ($urandom_range(3, 1)) send_byte($urandom_range(1) ? CH_SP : CH_HT);
            send_value($urandom_range(8, 0));
            send_byte(CH_CR);
            send_byte(CH_LF);
        end
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_byte(s[i]);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // status line: all three numbers run past the 16-bit ceiling
        send_text("HTTP/70000.65536 99999 Ok");
        send_byte(CH_CR);
        send_byte(CH_LF);
        wait_drained();

        // header block with random names, values and folds
        while (sent < 380)
        begin
            calm <= (sent >= 150 && sent < 250);
            send_header_line();
        end
        calm <= 1'b0;

        // either close the head and stream body bytes, or break the
        // syntax with noise and ride the sticky error
        if ($urandom_range(1))
        begin
            send_byte(CH_CR);
            send_byte(CH_LF);
        end
        repeat (24) send_byte(8'($urandom_range(255, 0)));

        wait_drained();
        repeat (8) @(posedge clk);
        if (tracker.fails == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
